// File: hdl/afk_pkg.sv
// ----------------------------------------------------------------------------
// afk_pkg
// Shared types, constants and the sine table builder for the three-joint
// arm forward kinematics core.
// ----------------------------------------------------------------------------
package afk_pkg;

  // Default datapath parameters
  localparam int FRAC_BITS_DEF = 16;
  localparam int LEN_BITS_DEF  = 10;
  localparam int FRAC_BITS_MAX = 24;

  // Field widths
  localparam int ANGLE_W = 9;
  localparam int SUM_W   = 11;
  localparam int DEG_W   = 9;
  localparam int KIDX_W  = 7;
  localparam int OUT_W   = 13;
  localparam int OUT_MAX = 4095;
  localparam int OUT_MIN = -4096;

  // Joint offsets in degrees
  localparam logic signed [SUM_W-1:0] SHOULDER_OFS = 11'sd30;
  localparam logic signed [SUM_W-1:0] ELBOW_OFS    = 11'sd210;

  // Pipeline sizing
  localparam int QUEUE_DEPTH = 2;
  localparam int BACK_STAGES = 5;
  localparam int CAPACITY    = 1 + QUEUE_DEPTH + BACK_STAGES;

  // Configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    REG_BASE_HEIGHT = 2'd0,
    REG_UPPER_LINK  = 2'd1,
    REG_FORE_LINK   = 2'd2
  } reg_idx_e;

  // One quarter-wave table lookup: index 0..90 and sign of the result
  typedef struct packed {
    logic              neg;
    logic [KIDX_W-1:0] k;
  } trig_sel_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    trig_sel_t sin1;
    trig_sel_t cos1;
    trig_sel_t sin2;
    trig_sel_t cos2;
    trig_sel_t sin23;
    trig_sel_t cos23;
  } afk_item_t;

  localparam int TBL_W = FRAC_BITS_MAX + 1;
  typedef logic [TBL_W-1:0] sin_tbl_t [91];

  localparam longint unsigned PI_Q32 = 64'h3_243F_6A89;

  // Shift-and-subtract quotient for the table build
  function automatic longint unsigned udiv64(longint unsigned num,
                                             longint unsigned dvs);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      q = {q[62:0], 1'b0};
      if (r >= dvs) begin
        r    = r - dvs;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave sine in Q(fb), built by a ten-term Taylor series in Q30
  function automatic sin_tbl_t build_sin_tbl(int fb);
    sin_tbl_t        tbl;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned den;
    longint          sum;
    for (int k = 0; k <= 90; k++) begin
      x    = udiv64(longint'(k) * PI_Q32 + 64'd360, 64'd720);
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 9; n++) begin
        den  = longint'((2 * n) * (2 * n + 1)) << 30;
        term = udiv64(term * x2 + (den >> 1), den);
        if ((n & 1) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      sum = (sum + (longint'(1) << (29 - fb))) >>> (30 - fb);
      if (sum > (longint'(1) << fb)) begin
        sum = longint'(1) << fb;
      end
      tbl[k] = TBL_W'(sum);
    end
    return tbl;
  endfunction

endpackage

// File: hdl/arm_forward_kinematics_3dof_core.sv
// ----------------------------------------------------------------------------
// arm_forward_kinematics_3dof_core
// Forward kinematics of a base/shoulder/elbow arm from whole-degree angles.
// ----------------------------------------------------------------------------
// Path from request acceptance to out_valid_o: input register, queue slot,
//   then five datapath stages ending in the output register.
// Throughput: one request per cycle; set by the fully pipelined lookup and
//   multiplier stages, stalls only on out_stall_i backpressure.
// Reset clears the link length registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module arm_forward_kinematics_3dof_core
  import afk_pkg::*;
#(
  parameter int FRACTION_BITS = FRAC_BITS_DEF,
  parameter int LENGTH_BITS   = LEN_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready,
  // requests
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [ANGLE_W-1:0] base_angle_i,
  input  logic signed [ANGLE_W-1:0] shoulder_angle_i,
  input  logic signed [ANGLE_W-1:0] elbow_angle_i,
  // results
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [OUT_W-1:0]   pos_x_o,
  output logic signed [OUT_W-1:0]   pos_y_o,
  output logic signed [OUT_W-1:0]   pos_z_o
);

  logic [LENGTH_BITS-1:0] base_height_q;
  logic [LENGTH_BITS-1:0] upper_link_q;
  logic [LENGTH_BITS-1:0] fore_link_q;
  logic                   cfg_wr;
  reg_idx_e               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_height_q <= '0;
      upper_link_q  <= '0;
      fore_link_q   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BASE_HEIGHT: base_height_q <= pwdata[LENGTH_BITS-1:0];
        REG_UPPER_LINK:  upper_link_q  <= pwdata[LENGTH_BITS-1:0];
        REG_FORE_LINK:   fore_link_q   <= pwdata[LENGTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BASE_HEIGHT: prdata = APB_DW'(base_height_q);
      REG_UPPER_LINK:  prdata = APB_DW'(upper_link_q);
      REG_FORE_LINK:   prdata = APB_DW'(fore_link_q);
      default:         prdata = '0;
    endcase
  end

  // Front -> queue -> back
  logic      fq_valid;
  logic      fq_ready;
  afk_item_t fq_item;
  logic      qb_valid;
  logic      qb_ready;
  afk_item_t qb_item;

  afk_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .base_angle_i     (base_angle_i),
    .shoulder_angle_i (shoulder_angle_i),
    .elbow_angle_i    (elbow_angle_i),
    .item_valid_o     (fq_valid),
    .item_o           (fq_item),
    .item_ready_i     (fq_ready)
  );

  afk_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_item_i  (fq_item),
    .push_ready_o (fq_ready),
    .pop_valid_o  (qb_valid),
    .pop_item_o   (qb_item),
    .pop_ready_i  (qb_ready)
  );

  afk_back #(
    .FRACTION_BITS (FRACTION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .base_height_i (base_height_q),
    .upper_link_i  (upper_link_q),
    .fore_link_i   (fore_link_q),
    .item_valid_i  (qb_valid),
    .item_i        (qb_item),
    .item_ready_o  (qb_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pos_z_o       (pos_z_o)
  );

  // Requests in flight, for the checks below
  localparam int OCC_W = $clog2(CAPACITY + 1);

  logic             in_acc;
  logic             out_acc;
  logic [OCC_W-1:0] occ_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (in_acc && !out_acc) begin
      occ_q <= occ_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      occ_q <= occ_q - 1'b1;
    end
  end

  // Never more requests inside than there are slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(CAPACITY))
    else $error("request count exceeds pipeline capacity");

  // A result always belongs to an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occ_q != '0)
    else $error("result shown with no request in flight");

  // Input backs up only once the input register and the queue are full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> occ_q >= OCC_W'(1 + QUEUE_DEPTH))
    else $error("input stalled with free slots");

  // A request accepted into an empty pipeline always reaches out_valid_o
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && occ_q == '0) |-> ##7 out_valid_o)
    else $error("result missing after pipeline latency");

endmodule

// File: hdl/afk_front.sv
// ----------------------------------------------------------------------------
// afk_front
// Takes joint angle requests, folds every angle sum into 0..359 degrees and
// turns each needed sine and cosine into a quarter-wave index and a sign.
// ----------------------------------------------------------------------------
module afk_front
  import afk_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [ANGLE_W-1:0] base_angle_i,
  input  logic signed [ANGLE_W-1:0] shoulder_angle_i,
  input  logic signed [ANGLE_W-1:0] elbow_angle_i,
  output logic                      item_valid_o,
  output afk_item_t                 item_o,
  input  logic                      item_ready_i
);

  // Fold a sum in -360..1023 into 0..359
  function automatic logic [DEG_W-1:0] wrap360(logic signed [SUM_W-1:0] a);
    logic signed [SUM_W-1:0] r;
    if (a < 0) begin
      r = a + 11'sd360;
    end else if (a >= 11'sd720) begin
      r = a - 11'sd720;
    end else if (a >= 11'sd360) begin
      r = a - 11'sd360;
    end else begin
      r = a;
    end
    return r[DEG_W-1:0];
  endfunction

  function automatic trig_sel_t sin_sel(logic [DEG_W-1:0] d);
    trig_sel_t       s;
    logic [DEG_W-1:0] k;
    if (d <= 9'd90) begin
      k     = d;
      s.neg = 1'b0;
    end else if (d <= 9'd180) begin
      k     = 9'd180 - d;
      s.neg = 1'b0;
    end else if (d <= 9'd270) begin
      k     = d - 9'd180;
      s.neg = 1'b1;
    end else begin
      k     = 9'd360 - d;
      s.neg = 1'b1;
    end
    s.k = k[KIDX_W-1:0];
    return s;
  endfunction

  // cos(d) = sin(d + 90)
  function automatic trig_sel_t cos_sel(logic [DEG_W-1:0] d);
    logic [DEG_W:0] e;
    e = {1'b0, d} + 10'd90;
    if (e >= 10'd360) begin
      e = e - 10'd360;
    end
    return sin_sel(e[DEG_W-1:0]);
  endfunction

  logic [DEG_W-1:0] th1;
  logic [DEG_W-1:0] th2;
  logic [DEG_W-1:0] th23;
  afk_item_t        item_d;
  afk_item_t        item_q;
  logic             vld_q;
  logic             load;

  always_comb begin
    th1  = wrap360(SUM_W'(base_angle_i));
    th2  = wrap360(SUM_W'(shoulder_angle_i) + SHOULDER_OFS);
    th23 = wrap360(SUM_W'(shoulder_angle_i) - SUM_W'(elbow_angle_i) + ELBOW_OFS);
    item_d.sin1  = sin_sel(th1);
    item_d.cos1  = cos_sel(th1);
    item_d.sin2  = sin_sel(th2);
    item_d.cos2  = cos_sel(th2);
    item_d.sin23 = sin_sel(th23);
    item_d.cos23 = cos_sel(th23);
  end

  assign load       = !vld_q || item_ready_i;
  assign in_stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule

// File: hdl/afk_queue.sv
// ----------------------------------------------------------------------------
// afk_queue
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module afk_queue
  import afk_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  input  afk_item_t push_item_i,
  output logic      push_ready_o,
  output logic      pop_valid_o,
  output afk_item_t pop_item_o,
  input  logic      pop_ready_i
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  afk_item_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [PTR_W:0]   count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != (PTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: hdl/afk_back.sv
// ----------------------------------------------------------------------------
// afk_back
// Five-stage datapath: table lookup, link products, reach and height sums,
// split products against the base angle, then rounding and saturation.
// ----------------------------------------------------------------------------
module afk_back
  import afk_pkg::*;
#(
  parameter int FRACTION_BITS = FRAC_BITS_DEF,
  parameter int LENGTH_BITS   = LEN_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [LENGTH_BITS-1:0]   base_height_i,
  input  logic [LENGTH_BITS-1:0]   upper_link_i,
  input  logic [LENGTH_BITS-1:0]   fore_link_i,
  input  logic                     item_valid_i,
  input  afk_item_t                item_i,
  output logic                     item_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [OUT_W-1:0]  pos_x_o,
  output logic signed [OUT_W-1:0]  pos_y_o,
  output logic signed [OUT_W-1:0]  pos_z_o
);

  localparam int F   = FRACTION_BITS;
  localparam int L   = LENGTH_BITS;
  localparam int TW  = F + 2;           // signed trig value
  localparam int PW  = L + F + 2;       // link times trig
  localparam int RW  = L + F + 2;       // reach
  localparam int DW  = L + F + 3;       // height sum
  localparam int HW  = L + F + 2;       // high part product
  localparam int LW  = 2 * F + 1;       // low part product
  localparam int MW  = L + 2 * F + 3;   // recombined product
  localparam int VW  = L + 4;           // rounded coordinate
  localparam int SW  = (VW > 14) ? VW : 14;

  localparam sin_tbl_t SIN_TBL = build_sin_tbl(FRACTION_BITS);

  localparam logic [DW-1:0]         ZHALF  = DW'(1) << (F - 1);
  localparam logic [MW-1:0]         MHALF  = MW'(1) << (2 * F - 1);
  localparam logic signed [SW-1:0]  SAT_HI = SW'(OUT_MAX);
  localparam logic signed [SW-1:0]  SAT_LO = SW'(OUT_MIN);

  function automatic logic signed [TW-1:0] trig_val(trig_sel_t s);
    logic [TW-1:0] mag;
    mag = {1'b0, SIN_TBL[s.k][F:0]};
    return s.neg ? $signed(-mag) : $signed(mag);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat(logic signed [VW-1:0] v);
    logic signed [SW-1:0] e;
    e = SW'(v);
    if (e > SAT_HI) begin
      e = SAT_HI;
    end else if (e < SAT_LO) begin
      e = SAT_LO;
    end
    return e[OUT_W-1:0];
  endfunction

  // Handshake: a stage loads when it is empty or its successor loads
  logic [BACK_STAGES:1] vld_q;
  logic [BACK_STAGES:1] rdy;

  always_comb begin
    rdy[BACK_STAGES] = !vld_q[BACK_STAGES] || !out_stall_i;
    for (int s = BACK_STAGES - 1; s >= 1; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
  end

  assign item_ready_o = rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[1]) begin
        vld_q[1] <= item_valid_i;
      end
      for (int s = 2; s <= BACK_STAGES; s++) begin
        if (rdy[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  // Stage 1: table lookups
  logic signed [TW-1:0] s1_sin1_q, s1_cos1_q, s1_sin2_q, s1_cos2_q;
  logic signed [TW-1:0] s1_sin23_q, s1_cos23_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s1_sin1_q  <= trig_val(item_i.sin1);
      s1_cos1_q  <= trig_val(item_i.cos1);
      s1_sin2_q  <= trig_val(item_i.sin2);
      s1_cos2_q  <= trig_val(item_i.cos2);
      s1_sin23_q <= trig_val(item_i.sin23);
      s1_cos23_q <= trig_val(item_i.cos23);
    end
  end

  // Stage 2: link products
  logic signed [PW-1:0] s2_c2_q, s2_c23_q, s2_s2_q, s2_s23_q;
  logic signed [TW-1:0] s2_sin1_q, s2_cos1_q;
  logic signed [L:0]    l2_s;
  logic signed [L:0]    l3_s;

  assign l2_s = $signed({1'b0, upper_link_i});
  assign l3_s = $signed({1'b0, fore_link_i});

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s2_c2_q   <= l2_s * s1_cos2_q;
      s2_c23_q  <= l3_s * s1_cos23_q;
      s2_s2_q   <= l2_s * s1_sin2_q;
      s2_s23_q  <= l3_s * s1_sin23_q;
      s2_sin1_q <= s1_sin1_q;
      s2_cos1_q <= s1_cos1_q;
    end
  end

  // Stage 3: reach and height sums
  logic signed [RW-1:0] s3_reach_q;
  logic signed [DW-1:0] s3_dz_q;
  logic signed [TW-1:0] s3_sin1_q, s3_cos1_q;
  logic signed [DW-1:0] l1_q;

  assign l1_q = $signed({3'b000, base_height_i, {F{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s3_reach_q <= RW'(s2_c2_q) + RW'(s2_c23_q);
      s3_dz_q    <= l1_q + DW'(s2_s2_q) + DW'(s2_s23_q);
      s3_sin1_q  <= s2_sin1_q;
      s3_cos1_q  <= s2_cos1_q;
    end
  end

  // Stage 4: split the reach magnitude and multiply each half; round z
  logic [RW-1:0] rmag_full;
  logic [RW-2:0] rmag;
  logic [L:0]    r_hi;
  logic [F-1:0]  r_lo;
  logic [TW-1:0] cmag_full;
  logic [TW-1:0] smag_full;
  logic [F:0]    cmag;
  logic [F:0]    smag;
  logic [DW-1:0] dzmag;
  logic [DW-1:0] zsum;

  always_comb begin
    rmag_full = s3_reach_q[RW-1] ? -s3_reach_q : s3_reach_q;
    rmag      = rmag_full[RW-2:0];
    r_hi      = rmag[RW-2:F];
    r_lo      = rmag[F-1:0];
    cmag_full = s3_cos1_q[TW-1] ? -s3_cos1_q : s3_cos1_q;
    smag_full = s3_sin1_q[TW-1] ? -s3_sin1_q : s3_sin1_q;
    cmag      = cmag_full[F:0];
    smag      = smag_full[F:0];
    dzmag     = s3_dz_q[DW-1] ? -s3_dz_q : s3_dz_q;
    zsum      = dzmag + ZHALF;
  end

  logic [HW-1:0]  s4_xhi_q, s4_yhi_q;
  logic [LW-1:0]  s4_xlo_q, s4_ylo_q;
  logic           s4_negx_q, s4_negy_q, s4_negz_q;
  logic [L+2:0]   s4_zmag_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s4_xhi_q  <= HW'(r_hi) * HW'(cmag);
      s4_xlo_q  <= LW'(r_lo) * LW'(cmag);
      s4_yhi_q  <= HW'(r_hi) * HW'(smag);
      s4_ylo_q  <= LW'(r_lo) * LW'(smag);
      s4_negx_q <= s3_cos1_q[TW-1] ^ s3_reach_q[RW-1];
      s4_negy_q <= s3_sin1_q[TW-1] ^ s3_reach_q[RW-1];
      s4_negz_q <= s3_dz_q[DW-1];
      s4_zmag_q <= zsum[DW-1:F];
    end
  end

  // Stage 5: recombine, round half away from zero, restore sign, saturate
  logic [MW-1:0]        xsum, ysum;
  logic [VW-1:0]        xm, ym, zm;
  logic signed [VW-1:0] xv, yv, zv;

  always_comb begin
    xsum = MW'({s4_xhi_q, {F{1'b0}}}) + MW'(s4_xlo_q) + MHALF;
    ysum = MW'({s4_yhi_q, {F{1'b0}}}) + MW'(s4_ylo_q) + MHALF;
    xm   = {1'b0, xsum[MW-1:2*F]};
    ym   = {1'b0, ysum[MW-1:2*F]};
    zm   = {1'b0, s4_zmag_q};
    // x is the negated product
    xv   = s4_negx_q ? $signed(xm) : $signed(-xm);
    yv   = s4_negy_q ? $signed(-ym) : $signed(ym);
    zv   = s4_negz_q ? $signed(-zm) : $signed(zm);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      pos_x_o <= sat(xv);
      pos_y_o <= sat(yv);
      pos_z_o <= sat(zv);
    end
  end

  assign out_valid_o = vld_q[BACK_STAGES];

endmodule

// File: tb/sv/afk_checker.sv
// ----------------------------------------------------------------------------
// afk_checker
// Watches the configuration port and both request/result channels of the arm
// forward kinematics core. Predicts the tool position of every accepted
// request and compares it field by field with the results, in order.
// ----------------------------------------------------------------------------
module afk_checker
  import afk_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  input  logic [APB_DW-1:0]         prdata,
  input  logic                      req_valid_i,
  input  logic                      req_stall_i,
  input  logic signed [ANGLE_W-1:0] base_angle_i,
  input  logic signed [ANGLE_W-1:0] shoulder_angle_i,
  input  logic signed [ANGLE_W-1:0] elbow_angle_i,
  input  logic                      rsp_valid_i,
  input  logic                      rsp_stall_i,
  input  logic signed [OUT_W-1:0]   pos_x_i,
  input  logic signed [OUT_W-1:0]   pos_y_i,
  input  logic signed [OUT_W-1:0]   pos_z_i,
  output int                        error_count_o,
  output int                        waiting_o,
  output int                        checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC  = FRAC_BITS_DEF;
  localparam int LEN_W = LEN_BITS_DEF;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } tool_pos_t;

  longint          quarter_sine [91];
  logic [LEN_W-1:0] height_len;
  logic [LEN_W-1:0] upper_len;
  logic [LEN_W-1:0] fore_len;
  logic [1:0]      reg_sel;
  tool_pos_t       tool_q [$];
  tool_pos_t       tool_exp;

  // Sine of k degrees (0..90) in Q(FRAC): Taylor series in Q30, then rounded
  function automatic longint taylor_sine(int k);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint unsigned den;
    longint          acc;
    ang    = (longint'(k) * PI_Q32 + 64'd360) / 64'd720;
    ang_sq = (ang * ang + (64'd1 << 29)) >> 30;
    term   = ang;
    acc    = longint'(ang);
    for (int n = 1; n <= 9; n++) begin
      den  = longint'(2 * n * (2 * n + 1)) << 30;
      term = (term * ang_sq + den / 64'd2) / den;
      acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
    if (acc > (longint'(1) << FRAC)) begin
      acc = longint'(1) << FRAC;
    end
    return acc;
  endfunction

  initial begin
    for (int k = 0; k <= 90; k++) begin
      quarter_sine[k] = taylor_sine(k);
    end
  end

  function automatic int wrap_deg(int v);
    int r;
    r = v % 360;
    return (r < 0) ? r + 360 : r;
  endfunction

  // d in 0..359
  function automatic longint sine_deg(int d);
    if (d <= 90) begin
      return quarter_sine[d];
    end else if (d <= 180) begin
      return quarter_sine[180 - d];
    end else if (d <= 270) begin
      return -quarter_sine[d - 180];
    end
    return -quarter_sine[360 - d];
  endfunction

  function automatic longint cosine_deg(int d);
    return sine_deg(wrap_deg(d + 90));
  endfunction

  // Q(FRAC) times Q(FRAC), back to integer, half away from zero
  function automatic longint scale_product(longint t, longint r);
    logic            neg;
    longint unsigned mt;
    longint unsigned mr;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned m;
    neg = (t < 0) != (r < 0);
    mt  = (t < 0) ? -t : t;
    mr  = (r < 0) ? -r : r;
    hi  = mr >> FRAC;
    lo  = mr & ((64'd1 << FRAC) - 64'd1);
    m   = (hi * mt + ((lo * mt) >> FRAC) + (64'd1 << (FRAC - 1))) >> FRAC;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint round_fixed(longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_coord(longint v);
    if (v > OUT_MAX) begin
      v = OUT_MAX;
    end
    if (v < OUT_MIN) begin
      v = OUT_MIN;
    end
    return OUT_W'(v);
  endfunction

  function automatic tool_pos_t predict_tool(logic signed [ANGLE_W-1:0] base,
                                             logic signed [ANGLE_W-1:0] shoulder,
                                             logic signed [ANGLE_W-1:0] elbow);
    tool_pos_t pos;
    int        th1;
    int        th2;
    int        th23;
    longint    reach;
    longint    height;
    th1    = wrap_deg(int'(base));
    th2    = wrap_deg(int'(shoulder) + int'(SHOULDER_OFS));
    th23   = wrap_deg(int'(shoulder) - int'(elbow) + int'(ELBOW_OFS));
    reach  = longint'(upper_len) * cosine_deg(th2) + longint'(fore_len) * cosine_deg(th23);
    height = (longint'(height_len) << FRAC) + longint'(upper_len) * sine_deg(th2)
             + longint'(fore_len) * sine_deg(th23);
    pos.x  = clamp_coord(-scale_product(cosine_deg(th1), reach));
    pos.y  = clamp_coord(scale_product(sine_deg(th1), reach));
    pos.z  = clamp_coord(round_fixed(height));
    return pos;
  endfunction

  task automatic compare_field(string name, longint expected, longint actual);
    if (expected != actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      error_count_o++;
    end
  endtask

  function automatic logic [LEN_W-1:0] reg_value(logic [1:0] sel);
    case (sel)
      REG_BASE_HEIGHT: return height_len;
      REG_UPPER_LINK:  return upper_len;
      REG_FORE_LINK:   return fore_len;
      default:         return '0;
    endcase
  endfunction

  assign reg_sel = paddr[APB_AW-1:2];

  initial begin
    error_count_o = 0;
    checked_o     = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_len <= '0;
      upper_len  <= '0;
      fore_len   <= '0;
      tool_q.delete();
      waiting_o  <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          // drop writes to unmapped indexes, keep only the length bits
          case (reg_sel)
            REG_BASE_HEIGHT: height_len <= pwdata[LEN_W-1:0];
            REG_UPPER_LINK:  upper_len  <= pwdata[LEN_W-1:0];
            REG_FORE_LINK:   fore_len   <= pwdata[LEN_W-1:0];
            default: ;
          endcase
        end else begin
          compare_field("prdata", longint'(reg_value(reg_sel)), longint'(prdata));
        end
      end
      if (rsp_valid_i && !rsp_stall_i) begin
        if (tool_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          error_count_o++;
        end else begin
          tool_exp = tool_q.pop_front();
          compare_field("pos_x", tool_exp.x, pos_x_i);
          compare_field("pos_y", tool_exp.y, pos_y_i);
          compare_field("pos_z", tool_exp.z, pos_z_i);
          checked_o++;
        end
      end
      if (req_valid_i && !req_stall_i) begin
        tool_q.push_back(predict_tool(base_angle_i, shoulder_angle_i, elbow_angle_i));
      end
      waiting_o <= tool_q.size();
    end
  end

endmodule

// File: tb/sv/tb_arm_forward_kinematics_3dof_core.sv
// ----------------------------------------------------------------------------
// tb_arm_forward_kinematics_3dof_core
// Drives joint angle requests and link length settings into the forward
// kinematics core under random idle and backpressure, and lets afk_checker
// predict and compare every tool position.
// ----------------------------------------------------------------------------
module tb_arm_forward_kinematics_3dof_core
  import afk_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REG_SPARE      = 3;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_BLOCKS    = 8;
  localparam int BLOCK_ITEMS    = 156;
  localparam int LINK_MAX       = (1 << LEN_BITS_DEF) - 1;

  logic                      clk_i            = 1'b0;
  logic                      rst_ni           = 1'b0;
  logic                      psel             = 1'b0;
  logic                      penable          = 1'b0;
  logic                      pwrite           = 1'b0;
  logic [APB_AW-1:0]         paddr            = '0;
  logic [APB_DW-1:0]         pwdata           = '0;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;
  logic                      in_valid_i       = 1'b0;
  logic                      in_stall_o;
  logic signed [ANGLE_W-1:0] base_angle_i     = '0;
  logic signed [ANGLE_W-1:0] shoulder_angle_i = '0;
  logic signed [ANGLE_W-1:0] elbow_angle_i    = '0;
  logic                      out_valid_o;
  logic                      out_stall_i      = 1'b0;
  logic signed [OUT_W-1:0]   pos_x_o;
  logic signed [OUT_W-1:0]   pos_y_o;
  logic signed [OUT_W-1:0]   pos_z_o;

  int error_count;
  int waiting;
  int checked;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;
  int sent_count   = 0;
  int link_sets    = 0;

  arm_forward_kinematics_3dof_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .base_angle_i     (base_angle_i),
    .shoulder_angle_i (shoulder_angle_i),
    .elbow_angle_i    (elbow_angle_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pos_x_o          (pos_x_o),
    .pos_y_o          (pos_y_o),
    .pos_z_o          (pos_z_o)
  );

  afk_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .req_valid_i      (in_valid_i),
    .req_stall_i      (in_stall_o),
    .base_angle_i     (base_angle_i),
    .shoulder_angle_i (shoulder_angle_i),
    .elbow_angle_i    (elbow_angle_i),
    .rsp_valid_i      (out_valid_o),
    .rsp_stall_i      (out_stall_i),
    .pos_x_i          (pos_x_o),
    .pos_y_i          (pos_y_o),
    .pos_z_i          (pos_z_o),
    .error_count_o    (error_count),
    .waiting_o        (waiting),
    .checked_o        (checked)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_arm_forward_kinematics_3dof_core: errors");
      $finish;
    end
  end

  task automatic apb_access(input int idx, input logic write, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= APB_AW'(idx) << 2;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // bus returns to idle between accesses
    @(posedge clk_i);
  endtask

  // Program the three lengths with junk above the length bits, poke the
  // unmapped slot, then read the three lengths back
  task automatic set_links(input int height, input int upper, input int fore);
    apb_access(REG_BASE_HEIGHT, 1'b1, (APB_DW'($urandom) << LEN_BITS_DEF) | APB_DW'(height));
    apb_access(REG_UPPER_LINK, 1'b1, (APB_DW'($urandom) << LEN_BITS_DEF) | APB_DW'(upper));
    apb_access(REG_FORE_LINK, 1'b1, (APB_DW'($urandom) << LEN_BITS_DEF) | APB_DW'(fore));
    apb_access(REG_SPARE, 1'b1, APB_DW'($urandom));
    apb_access(REG_BASE_HEIGHT, 1'b0, '0);
    apb_access(REG_UPPER_LINK, 1'b0, '0);
    apb_access(REG_FORE_LINK, 1'b0, '0);
    link_sets++;
  endtask

  task automatic send_angles(input int base, input int shoulder, input int elbow);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    base_angle_i     <= ANGLE_W'(base);
    shoulder_angle_i <= ANGLE_W'(shoulder);
    elbow_angle_i    <= ANGLE_W'(elbow);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
  endtask

  // Hold off until every outstanding request has produced its result
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic int pick_angle();
    case ($urandom_range(0, 9))
      0, 1:    return int'($urandom_range(0, 511)) - 256;
      2:       return 90 * (int'($urandom_range(0, 4)) - 2) + int'($urandom_range(0, 2)) - 1;
      default: return int'($urandom_range(0, 360)) - 180;
    endcase
  endfunction

  initial begin : stimulus
    int height;
    int upper;
    int fore;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lengths still at reset
    send_angles(0, 0, 0);
    send_angles(90, 60, 180);
    settle();

    set_links(100, 400, 300);
    send_angles(0, 0, 0);
    send_angles(-180, -180, -180);
    send_angles(180, 180, 180);
    send_angles(-256, -256, -256);
    send_angles(255, 255, 255);
    send_angles(90, 60, 180);
    send_angles(-90, -120, 0);
    send_angles(30, 15, 90);
    send_angles(120, -210, 45);
    send_angles(-150, 150, -90);
    send_angles(-60, -30, 210);
    send_angles(45, 240, -240);
    send_angles(0, 1, -1);
    settle();

    set_links(LINK_MAX, LINK_MAX, LINK_MAX);
    send_angles(0, 60, 180);
    send_angles(180, -120, 180);
    send_angles(-90, -120, 0);
    send_angles(90, 60, 0);
    settle();

    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      case (blk)
        0: begin height = LINK_MAX; upper = LINK_MAX; fore = LINK_MAX; end
        1: begin height = 0;        upper = LINK_MAX; fore = 0;        end
        2: begin height = LINK_MAX; upper = 0;        fore = LINK_MAX; end
        default: begin
          height = $urandom_range(0, LINK_MAX);
          upper  = $urandom_range(0, LINK_MAX);
          fore   = $urandom_range(0, LINK_MAX);
        end
      endcase
      set_links(height, upper, fore);
      case (blk % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        send_angles(pick_angle(), pick_angle(), pick_angle());
        if (i == BLOCK_ITEMS / 2) begin
          settle();
        end
      end
      settle();
    end

    idle_pct  = 0;
    stall_pct = 0;
    settle();
    $display("covered %0d angle requests over %0d link length settings", sent_count, link_sets);
    $display("compared %0d tool positions under idle, backpressure and mixed traffic",
             checked);
    if (error_count == 0 && waiting == 0) begin
      $display("tb_arm_forward_kinematics_3dof_core: clean");
    end else begin
      $display("tb_arm_forward_kinematics_3dof_core: errors");
    end
    $finish;
  end

endmodule
